/* design/byte_signature_scanner_defines.svh */
// Assertion shorthands for the signature scanner checkers.
// Both expect clk_i in the scope of use; BSS_ASSERT also expects rst_ni.
`ifndef BYTE_SIGNATURE_SCANNER_DEFINES_SVH
`define BYTE_SIGNATURE_SCANNER_DEFINES_SVH

// Check on every rising edge, silenced while reset is asserted.
`define BSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge, reset included.
`define BSS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/bss_pkg.sv */
package bss_pkg;

  typedef enum logic [1:0] {
    ModeSigByte = 2'd0,
    ModeSigLen  = 2'd1,
    ModeScan    = 2'd2,
    ModeStart   = 2'd3
  } bss_mode_e;

  localparam int unsigned SlotW    = 2;
  localparam int unsigned BytePosW = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OffsetW  = 16;

  localparam logic [OffsetW-1:0] OffsetMax = '1;

  // hit queue between the match front and the result back
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    bss_mode_e             mode;
    logic [SlotW-1:0]      slot;
    logic [BytePosW-1:0]   byte_pos;
    logic [ByteW-1:0]      value;
  } bss_in_t;

  typedef struct packed {
    logic [SlotW-1:0]   match_slot;
    logic [OffsetW-1:0] match_offset;
    logic               last;
  } bss_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bss_fifo_stat_t;

endpackage

/* design/bss_front.sv */
module bss_front #(
  parameter int unsigned NUM_SIGS    = 4,
  parameter int unsigned MAX_SIG_LEN = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  bss_pkg::bss_in_t                            data_i,
  input  logic                                        q_full_i,
  output logic                                        q_push_o,
  output logic [NUM_SIGS-1:0]                         q_hit_o,
  output logic [NUM_SIGS-1:0][bss_pkg::OffsetW-1:0]   q_off_o
);
  import bss_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_SIG_LEN + 1);
  localparam int unsigned PosW = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;

  logic [NUM_SIGS-1:0][MAX_SIG_LEN-1:0][ByteW-1:0] sig_q, sig_d;
  logic [NUM_SIGS-1:0][LenW-1:0]                   len_q, len_d;
  logic [MAX_SIG_LEN-1:0][ByteW-1:0]               hist_q, hist_d;
  logic [OffsetW-1:0]                              pos_q, pos_d;

  logic [MAX_SIG_LEN-1:0][ByteW-1:0] win;
  logic                              accept;
  logic [NUM_SIGS-1:0]               hit;
  logic [NUM_SIGS-1:0][OffsetW-1:0]  off;

  assign accept = push_i && !q_full_i;

  // window as it stands after this byte, newest at index 0
  always_comb begin
    win[0] = data_i.value;
    for (int unsigned k = 1; k < MAX_SIG_LEN; k++) begin
      win[k] = hist_q[k-1];
    end
  end

  // align each signature so its last byte sits on the newest byte
  always_comb begin
    logic [LenW-1:0] tap;
    logic            all_eq;
    logic            fits;
    for (int unsigned s = 0; s < NUM_SIGS; s++) begin
      all_eq = 1'b1;
      tap    = '0;
      for (int unsigned j = 0; j < MAX_SIG_LEN; j++) begin
        if (LenW'(j) < len_q[s]) begin
          tap = len_q[s] - LenW'(j) - LenW'(1);
          if (sig_q[s][j] != win[tap[PosW-1:0]]) begin
            all_eq = 1'b0;
          end
        end
      end
      fits   = ({1'b0, pos_q} + 17'd1) >= 17'(len_q[s]);
      hit[s] = (len_q[s] != '0) && fits && all_eq;
      off[s] = (pos_q == OffsetMax) ? OffsetMax
                                    : pos_q + 16'd1 - OffsetW'(len_q[s]);
    end
  end

  always_comb begin
    sig_d  = sig_q;
    len_d  = len_q;
    hist_d = hist_q;
    pos_d  = pos_q;
    if (accept) begin
      unique case (data_i.mode)
        ModeSigByte: begin
          for (int unsigned s = 0; s < NUM_SIGS; s++) begin
            for (int unsigned j = 0; j < MAX_SIG_LEN; j++) begin
              if (32'(data_i.slot) == s && 32'(data_i.byte_pos) == j) begin
                sig_d[s][j] = data_i.value;
              end
            end
          end
        end
        ModeSigLen: begin
          for (int unsigned s = 0; s < NUM_SIGS; s++) begin
            if (32'(data_i.slot) == s && 32'(data_i.value) <= MAX_SIG_LEN) begin
              len_d[s] = LenW'(data_i.value);
            end
          end
        end
        ModeScan: begin
          hist_d = win;
          if (pos_q != OffsetMax) begin
            pos_d = pos_q + 16'd1;
          end
        end
        ModeStart: begin
          hist_d = '0;
          pos_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_q  <= '0;
      len_q  <= '0;
      hist_q <= '0;
      pos_q  <= '0;
    end else begin
      sig_q  <= sig_d;
      len_q  <= len_d;
      hist_q <= hist_d;
      pos_q  <= pos_d;
    end
  end

  assign q_push_o = accept && (data_i.mode == ModeScan) && (|hit);
  assign q_hit_o  = hit;
  assign q_off_o  = off;

endmodule

/* design/bss_fifo.sv */
module bss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  logic [WIDTH-1:0]        data_i,
  input  logic                    pop_i,
  output logic [WIDTH-1:0]        data_o,
  output bss_pkg::bss_fifo_stat_t stat_o
);
  import bss_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign data_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* design/bss_back.sv */
module bss_back #(
  parameter int unsigned NUM_SIGS = 4
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      q_empty_i,
  input  logic [NUM_SIGS-1:0]                       q_hit_i,
  input  logic [NUM_SIGS-1:0][bss_pkg::OffsetW-1:0] q_off_i,
  output logic                                      q_pop_o,
  input  logic                                      pop_i,
  output logic                                      empty_o,
  output bss_pkg::bss_out_t                         res_o
);
  import bss_pkg::*;

  localparam int unsigned RankW = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_SIGS + 1);

  logic                              ent_vld_q, ent_vld_d;
  logic [NUM_SIGS-1:0]               hit_q, hit_d;
  logic [NUM_SIGS-1:0][OffsetW-1:0]  off_q, off_d;
  logic [NUM_SIGS-1:0][RankW-1:0]    rank_q, rank_d;
  logic [RankW-1:0]                  last_q, last_d;
  logic [RankW-1:0]                  k_q, k_d;
  logic                              out_vld_q, out_vld_d;
  bss_out_t                          out_q, out_d;

  logic [NUM_SIGS-1:0]               sel;
  logic [SlotW-1:0]                  sel_slot;
  logic [OffsetW-1:0]                sel_off;
  logic                              out_load, emit, is_last, ent_free;
  logic [NUM_SIGS-1:0][RankW-1:0]    new_rank;
  logic [RankW-1:0]                  new_last;

  // pick the hit whose rank is due
  always_comb begin
    sel_slot = '0;
    sel_off  = '0;
    for (int unsigned i = 0; i < NUM_SIGS; i++) begin
      sel[i] = hit_q[i] && (rank_q[i] == k_q);
      if (sel[i]) begin
        sel_slot = sel_slot | SlotW'(i);
        sel_off  = sel_off | off_q[i];
      end
    end
  end

  // rank every hit by offset, then slot
  always_comb begin
    logic [RankW-1:0] r;
    logic [CntW-1:0]  n;
    n = '0;
    for (int unsigned i = 0; i < NUM_SIGS; i++) begin
      r = '0;
      for (int unsigned j = 0; j < NUM_SIGS; j++) begin
        if (j != i && q_hit_i[i] && q_hit_i[j] &&
            (q_off_i[j] < q_off_i[i] || (q_off_i[j] == q_off_i[i] && j < i))) begin
          r = r + RankW'(1);
        end
      end
      new_rank[i] = r;
      n = n + CntW'(q_hit_i[i]);
    end
    new_last = RankW'(n - CntW'(1));
  end

  assign out_load = !out_vld_q || pop_i;
  assign emit     = ent_vld_q && out_load;
  assign is_last  = (k_q == last_q);
  assign ent_free = !ent_vld_q || (emit && is_last);
  assign q_pop_o  = ent_free && !q_empty_i;

  always_comb begin
    ent_vld_d = ent_vld_q;
    hit_d     = hit_q;
    off_d     = off_q;
    rank_d    = rank_q;
    last_d    = last_q;
    k_d       = k_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (q_pop_o) begin
      ent_vld_d = 1'b1;
      hit_d     = q_hit_i;
      off_d     = q_off_i;
      rank_d    = new_rank;
      last_d    = new_last;
      k_d       = '0;
    end else if (emit && is_last) begin
      ent_vld_d = 1'b0;
    end else if (emit) begin
      k_d = k_q + RankW'(1);
    end
    if (out_load) begin
      out_vld_d = emit;
      if (emit) begin
        out_d.match_slot   = sel_slot;
        out_d.match_offset = sel_off;
        out_d.last         = is_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      ent_vld_q <= ent_vld_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    off_q  <= off_d;
    rank_q <= rank_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

endmodule

/* design/byte_signature_scanner.sv */
// Channel  | Direction | Handshake          | Word
// ---------+-----------+--------------------+-----------------------------
// input    | in        | push / full        | data_i : mode, slot, byte_pos, value
// result   | out       | empty / pop        | res_o  : match_slot, match_offset, last
//
// One input word is taken per cycle while the hit queue has room; load, start
// and scan words without a hit never enter the queue.
// A scan word with n hits yields n result words, one result word per cycle while the
// receiver pops; the first goes through the hit queue, entry and result registers.
// Reset clears signatures, lengths, history and offset at once, with no sweep.
// Either side may stall: the two-entry hit queue and the result register
// absorb it, and full rises only once the queue holds two scan words.
module byte_signature_scanner #(
  parameter int unsigned NUM_SIGS    = 4,
  parameter int unsigned MAX_SIG_LEN = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  bss_pkg::bss_in_t  data_i,
  output logic              empty,
  input  logic              pop,
  output bss_pkg::bss_out_t res_o
);
  import bss_pkg::*;

  localparam int unsigned QueueW = NUM_SIGS * (OffsetW + 1);

  // hit words from the front, one per scan byte that matched anything
  logic                             q_push, q_pop;
  logic [NUM_SIGS-1:0]              f_hit, b_hit;
  logic [NUM_SIGS-1:0][OffsetW-1:0] f_off, b_off;
  bss_fifo_stat_t                   q_stat;

  // front: hold the signatures, shift the window, compare all slots at once
  bss_front #(
    .NUM_SIGS    (NUM_SIGS),
    .MAX_SIG_LEN (MAX_SIG_LEN)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (data_i),
    .q_full_i (q_stat.full),
    .q_push_o (q_push),
    .q_hit_o  (f_hit),
    .q_off_o  (f_off)
  );

  // decouple the front from result stalls
  bss_fifo #(
    .WIDTH (QueueW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({f_hit, f_off}),
    .pop_i  (q_pop),
    .data_o ({b_hit, b_off}),
    .stat_o (q_stat)
  );

  // back: rank the hits of one byte and drain them in offset order
  bss_back #(
    .NUM_SIGS (NUM_SIGS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_stat.empty),
    .q_hit_i   (b_hit),
    .q_off_i   (b_off),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res_o)
  );

  // refuse new words only when the hit queue is full
  assign full = q_stat.full;

endmodule

/* design/bss_checker.sv */
`include "byte_signature_scanner_defines.svh"

module bss_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input bss_pkg::bss_out_t res_o
);

  `BSS_ASSERT_ALWAYS(a_reset_idle, (!rst_ni) |-> (empty && !full), "not idle in reset")

  `BSS_ASSERT(a_hold_stalled, (!empty && !pop) |=> (!empty && $stable(res_o)), "result changed while stalled")

  `BSS_ASSERT(a_burst_continues, (!empty && pop && !res_o.last) |=> !empty, "gap inside a result burst")

  `BSS_ASSERT(a_burst_order, (!empty && pop && !res_o.last) |=> (res_o.match_offset > $past(res_o.match_offset) || (res_o.match_offset == $past(res_o.match_offset) && res_o.match_slot > $past(res_o.match_slot))), "results out of order")

endmodule

bind byte_signature_scanner bss_checker u_bss_checker (.*);

/* tb/byte_signature_scanner_tb.sv */
`timescale 1ns / 100ps

module byte_signature_scanner_tb;
  import bss_pkg::*;

  localparam int unsigned NumSigs    = 4;
  localparam int unsigned MaxLen     = 32;
  localparam int unsigned CycleLimit = 400000;

  // Directed rows: n is the number of typed hits (0 or 1), or -1 to use the predictor.
  typedef struct {
    bss_mode_e   mode;
    int unsigned slot;
    int unsigned pos;
    int unsigned value;
    int          n;
    int unsigned hit_slot;
    int unsigned hit_off;
  } dir_row_t;

  logic     clk_i  = 1'b0;
  logic     rst_ni = 1'b1;
  logic     push   = 1'b0;
  logic     pop    = 1'b0;
  logic     full;
  logic     empty;
  bss_in_t  data_i = '0;
  bss_out_t res_o;

  // Typed expectation travels with the word, driven on the same edge as data_i.
  int       row_typed_n = -1;
  bss_out_t row_typed   = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned sent_cnt      = 0;
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;

  // Predictor state: signatures, lengths, history (index 0 newest), scan offset.
  logic [ByteW-1:0]   sig_mem [NumSigs][MaxLen] = '{default: '0};
  logic [5:0]         sig_len [NumSigs]         = '{default: '0};
  logic [ByteW-1:0]   hist    [MaxLen]          = '{default: '0};
  logic [OffsetW-1:0] scan_pos                  = '0;
  bss_out_t           word_hits [$];
  bss_out_t           pending_hits [$];

  // Sender-side copy of what was loaded, used to plant signatures in the stream.
  logic [ByteW-1:0]   plan_mem [NumSigs][MaxLen] = '{default: '0};
  int unsigned        plan_len [NumSigs]         = '{default: 0};

  dir_row_t dir_tab [21] = '{
    // nothing loaded yet: scans hit nothing
    '{ModeScan,    0,  0, 'h00, 0, 0, 0},
    // lengths above the signature size are dropped
    '{ModeSigLen,  0,  0, 'hFF, 0, 0, 0},
    '{ModeSigLen,  0,  0, 'd33, 0, 0, 0},
    '{ModeScan,    0,  0, 'h00, 0, 0, 0},
    // slot 0 becomes the one-byte signature 00
    '{ModeSigLen,  0,  0, 'd1,  0, 0, 0},
    '{ModeScan,    0,  0, 'h00, 1, 0, 2},
    // full-length signature in slot 3, last byte FF
    '{ModeSigByte, 3, 31, 'hFF, 0, 0, 0},
    '{ModeSigLen,  3,  0, 'd32, 0, 0, 0},
    '{ModeSigByte, 1,  0, 'hFF, 0, 0, 0},
    '{ModeSigByte, 1,  1, 'h80, 0, 0, 0},
    '{ModeSigLen,  1,  0, 'd2,  0, 0, 0},
    '{ModeScan,    2, 17, 'hFF, -1, 0, 0},
    '{ModeScan,    1,  5, 'h80, -1, 0, 0},
    // three zero bytes in slot 2
    '{ModeSigLen,  2,  0, 'd3,  0, 0, 0},
    // new buffer: slot 2 must not fit until three bytes are in
    '{ModeStart,   0,  0, 'h00, 0, 0, 0},
    '{ModeScan,    0,  0, 'h00, 1, 0, 0},
    '{ModeScan,    0,  0, 'h00, 1, 0, 1},
    // slot 2 starts earlier than slot 0, so it comes first
    '{ModeScan,    0,  0, 'h00, -1, 0, 0},
    '{ModeSigLen,  0,  0, 'd0,  0, 0, 0},
    '{ModeScan,    3, 31, 'h00, -1, 0, 0},
    '{ModeStart,   3, 31, 'hFF, 0, 0, 0}
  };

  byte_signature_scanner i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .data_i (data_i),
    .empty  (empty),
    .pop    (pop),
    .res_o  (res_o)
  );

  always #6 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("** byte_signature_scanner: FAILED **");
      $finish;
    end
  end

  // Receiver: stall pop at random at the current idle rate.
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bss_in_t pack_word(bss_mode_e m, int unsigned s, int unsigned p,
                                        int unsigned v);
    bss_in_t w;
    w.mode     = m;
    w.slot     = SlotW'(s);
    w.byte_pos = BytePosW'(p);
    w.value    = ByteW'(v);
    return w;
  endfunction

  // Mostly a four-byte alphabet so that short signatures hit often.
  function automatic int unsigned pick_sym();
    int unsigned k;
    k = $urandom_range(9);
    case (k % 4)
      0: k = (k < 8) ? 'h00 : $urandom_range(255);
      1: k = (k < 8) ? 'h5A : $urandom_range(255);
      2: k = 'hA5;
      default: k = 'hFF;
    endcase
    return k;
  endfunction

  // Apply one accepted word to the predictor state; collect its hits in word_hits.
  task automatic match_word(input bss_in_t w);
    bss_out_t    hit;
    int unsigned cur, len, off, k, j;
    bit          ok;
    word_hits.delete();
    case (w.mode)
      ModeSigByte: sig_mem[w.slot][w.byte_pos] = w.value;
      ModeSigLen: begin
        if (w.value <= MaxLen) sig_len[w.slot] = w.value[5:0];
      end
      ModeStart: begin
        foreach (hist[i]) hist[i] = '0;
        scan_pos = '0;
      end
      ModeScan: begin
        for (k = MaxLen - 1; k > 0; k--) hist[k] = hist[k-1];
        hist[0] = w.value;
        cur = scan_pos;
        for (int unsigned s = 0; s < NumSigs; s++) begin
          len = sig_len[s];
          // skip unused slots and signatures longer than the buffer so far
          if (len != 0 && cur + 1 >= len) begin
            ok = 1'b1;
            for (j = 0; j < len; j++) begin
              if (sig_mem[s][j] != hist[len-1-j]) ok = 1'b0;
            end
            if (ok) begin
              off = (cur >= OffsetMax) ? OffsetMax : cur + 1 - len;
              hit.match_slot   = SlotW'(s);
              hit.match_offset = OffsetW'(off);
              hit.last         = 1'b0;
              // keep ascending offset; equal offsets stay in slot order
              k = word_hits.size();
              while (k > 0 && word_hits[k-1].match_offset > off) k--;
              word_hits.insert(k, hit);
            end
          end
        end
        if (scan_pos != OffsetMax) scan_pos++;
        foreach (word_hits[i]) word_hits[i].last = (i == word_hits.size() - 1);
      end
    endcase
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Sample both handshakes at the edge; predict first, then check.
  always @(posedge clk_i) begin
    bss_out_t want;
    if (rst_ni && push && !full) begin
      match_word(data_i);
      if (row_typed_n < 0) begin
        foreach (word_hits[i]) pending_hits.push_back(word_hits[i]);
      end else if (row_typed_n == 1) begin
        pending_hits.push_back(row_typed);
      end
    end
    if (rst_ni && pop && !empty) begin
      if (pending_hits.size() == 0) begin
        err_cnt++;
        $display("%0t: stray result: expected none, got slot %0d offset %0d last %0d",
                 $time, res_o.match_slot, res_o.match_offset, res_o.last);
      end else begin
        want = pending_hits.pop_front();
        check_field("match_slot", want.match_slot, res_o.match_slot);
        check_field("match_offset", want.match_offset, res_o.match_offset);
        check_field("last", want.last, res_o.last);
      end
    end
  end

  // Offer one word, idling first at random, and hold it until it is taken.
  task automatic send_word(input bss_in_t w, input int typed_n = -1,
                           input bss_out_t typed = '0);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    push        <= 1'b1;
    data_i      <= w;
    row_typed_n <= typed_n;
    row_typed   <= typed;
    do @(posedge clk_i); while (full);
    sent_cnt++;
    if (w.mode == ModeSigByte) plan_mem[w.slot][w.byte_pos] = w.value;
    if (w.mode == ModeSigLen && w.value <= MaxLen) plan_len[w.slot] = w.value;
  endtask

  // Drop push and hold until every pending hit has come out.
  task automatic drain_results();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_stream(input int unsigned n);
    int unsigned stop_at, pick, s, len, k;
    stop_at = sent_cnt + n;
    while (sent_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        // reload a slot, mostly short, sometimes longer up to full size, oversize or unused
        s = $urandom_range(3);
        k = $urandom_range(99);
        len = (k < 70) ? $urandom_range(4, 1) : (k < 85) ? $urandom_range(32, 5) :
              (k < 95) ? $urandom_range(255, 33) : 0;
        for (k = 0; k < len && k < MaxLen; k++)
          send_word(pack_word(ModeSigByte, s, k, pick_sym()));
        send_word(pack_word(ModeSigLen, s, $urandom_range(31), len));
      end else if (pick < 14) begin
        send_word(pack_word(ModeStart, $urandom_range(3), $urandom_range(31),
                            $urandom_range(255)));
      end else if (pick < 22) begin
        // stray load with every field random
        send_word(pack_word($urandom_range(1) ? ModeSigLen : ModeSigByte, $urandom_range(3),
                            $urandom_range(31), $urandom_range(255)));
      end else if (pick < 45) begin
        // plant a loaded signature in the stream
        s = $urandom_range(3);
        for (k = 0; k < plan_len[s]; k++)
          send_word(pack_word(ModeScan, $urandom_range(3), $urandom_range(31), plan_mem[s][k]));
      end else begin
        for (k = $urandom_range(6, 1); k > 0; k--)
          send_word(pack_word(ModeScan, $urandom_range(3), $urandom_range(31), pick_sym()));
      end
    end
  endtask

  initial begin
    bss_out_t typed;
    rst_ni <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles lightly, receiver heavily
    send_idle_pct = 25;
    recv_idle_pct = 60;
    foreach (dir_tab[r]) begin
      typed.match_slot   = SlotW'(dir_tab[r].hit_slot);
      typed.match_offset = OffsetW'(dir_tab[r].hit_off);
      typed.last         = 1'b1;
      send_word(pack_word(dir_tab[r].mode, dir_tab[r].slot, dir_tab[r].pos,
                          dir_tab[r].value), dir_tab[r].n, typed);
    end
    random_stream(100);
    drain_results();

    // swap the idle rates
    send_idle_pct = 60;
    recv_idle_pct = 25;
    random_stream(100);
    drain_results();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_stream(90);
    drain_results();
    repeat (8) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("** byte_signature_scanner: PASSED **");
    end else begin
      $display("** byte_signature_scanner: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/bss_pkg.sv
design/bss_front.sv
design/bss_fifo.sv
design/bss_back.sv
design/byte_signature_scanner.sv
design/bss_checker.sv
tb/byte_signature_scanner_tb.sv
